FILE: sv/phtt_pkg.sv
// shared types, constants and hash round function for the pointer hash tracking table
`default_nettype none
package phtt_pkg;

   localparam int SMALL_TABLE_BITS_DEF = 8;
   localparam int LARGE_TABLE_BITS_DEF = 10;

   localparam int KEY_W  = 64;
   localparam int SLOT_W = 10;
   localparam int USED_W = 11;

   localparam logic [USED_W-1:0] COUNT_MAX = {USED_W{1'b1}};

   // four hash rounds of shifted adds, each but the last followed by an xor-shift
   localparam int MIX_STEPS = 4;
   localparam logic [1:0] MIX_LAST = 2'(MIX_STEPS - 1);

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_INSERTED  = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   function automatic logic [KEY_W-1:0] mix_step(input logic [KEY_W-1:0] k,
                                                 input logic [1:0] step);
      logic [KEY_W-1:0] t;
      t = '0;
      unique case (step)
         2'd0: begin
            t = ~k + (k << 21);
            t = t ^ (t >> 24);
         end
         2'd1: begin
            t = (k + (k << 3)) + (k << 8);
            t = t ^ (t >> 14);
         end
         2'd2: begin
            t = (k + (k << 2)) + (k << 4);
            t = t ^ (t >> 28);
         end
         2'd3: begin
            t = k + (k << 31);
         end
         default: begin
            t = k;
         end
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

FILE: sv/phtt_hash.sv
// iterative 64-bit key hash, one round per cycle
`default_nettype none
module phtt_hash
   import phtt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [KEY_W-1:0] key,
   output logic                  done,
   output logic [KEY_W-1:0]      hash
);

   logic [KEY_W-1:0] k_ff, k_in;
   logic [1:0]       step_ff, step_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   always_comb begin
      k_in    = k_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         k_in    = mix_step(key, 2'd0);
         step_in = 2'd1;
         run_in  = 1'b1;
      end else if (run_ff) begin
         k_in    = mix_step(k_ff, step_ff);
         step_in = step_ff + 2'd1;
         if (step_ff == MIX_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      k_ff <= k_in;
   end

   assign done = done_ff;
   assign hash = k_ff;

endmodule
`default_nettype wire

FILE: sv/phtt_key_ram.sv
// simple dual-port key memory with registered read data
`default_nettype none
module phtt_key_ram #(
   parameter int ADDR_BITS = 8,
   parameter int DATA_W    = 64
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]    wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_W-1:0]         rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/pointer_hash_tracking_table.sv
// pointer hash tracking table: two open-addressing key tables with linear probing
//
// each req_ transaction carries a 64-bit key, a table select and an insert flag; one
// rsp_ transaction per request returns status (found, inserted, not found, full), the
// slot index and the use count of the selected table.
// both channels are valid/stall; req_stall is low only while the block is idle.
// after the four hash rounds the home slot is read, then a second slot at a hash-derived
// offset, then a linear probe reads the following slots until a match or an empty slot,
// at most the table size on a full table. one key memory read per cycle sets this pace.
// the response sits in an output register: a stalled response does not block the
// next request, though a finished result waits until that register is free.
// after reset both tables are swept to zero, one entry per cycle in both at once,
// over 2^max(SMALL_TABLE_BITS, LARGE_TABLE_BITS) entries (1024 by default); requests
// are held off with req_stall during the sweep.
`default_nettype none
module pointer_hash_tracking_table
   import phtt_pkg::*;
#(
   parameter int SMALL_TABLE_BITS = SMALL_TABLE_BITS_DEF,
   parameter int LARGE_TABLE_BITS = LARGE_TABLE_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_opcode,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic              req_table_sel,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [SLOT_W-1:0]      rsp_slot,
   output logic [USED_W-1:0]      rsp_used_count
);

   localparam int LB = (LARGE_TABLE_BITS > SMALL_TABLE_BITS) ? LARGE_TABLE_BITS
                                                             : SMALL_TABLE_BITS;
   localparam logic [LB-1:0] SMASK = LB'((64'd1 << SMALL_TABLE_BITS) - 64'd1);
   localparam logic [LB-1:0] LMASK = LB'((64'd1 << LARGE_TABLE_BITS) - 64'd1);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_HASH   = 7'b0000100,
      S_HOME   = 7'b0001000,
      S_SECOND = 7'b0010000,
      S_PROBE  = 7'b0100000,
      S_RESULT = 7'b1000000
   } state_type;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [LB-1:0] idx);
      logic [SLOT_W-1:0] r;
      r = '0;
      for (int i = 0; i < SLOT_W; i++) begin
         if (i < LB) begin
            r[i] = idx[i];
         end
      end
      return r;
   endfunction

   state_type         state_ff, state_in;
   logic [LB-1:0]     clr_ff, clr_in;
   logic              op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              sel_ff, sel_in;
   logic [LB-1:0]     home_ff, home_in;
   logic [LB-1:0]     pos_ff, pos_in;
   logic [LB-1:0]     cnt_ff, cnt_in;
   logic [USED_W-1:0] small_used_ff, small_used_in;
   logic [USED_W-1:0] large_used_ff, large_used_in;
   status_type        pend_status_ff, pend_status_in;
   logic [SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   logic [USED_W-1:0] pend_used_ff, pend_used_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [USED_W-1:0] rsp_used_ff, rsp_used_in;

   logic              hash_start, hash_done;
   logic [KEY_W-1:0]  hash;
   logic [KEY_W-1:0]  hash_sh_small, hash_sh_large;
   logic [LB-1:0]     mask, home_calc, offset, pos2, pos_next, rd_addr;
   logic [KEY_W-1:0]  small_rd, large_rd, rd_data;
   logic              key_eq, slot_empty, insert, clearing;
   logic [USED_W-1:0] used_sel, used_inc;
   logic              out_free;

   phtt_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_key),
      .done  (hash_done),
      .hash  (hash)
   );

   assign clearing = (state_ff == S_CLEAR);

   phtt_key_ram #(.ADDR_BITS(SMALL_TABLE_BITS), .DATA_W(KEY_W)) u_small_ram (
      .clock   (clock),
      .wr_en   (clearing || (insert && !sel_ff)),
      .wr_addr (clearing ? clr_ff[SMALL_TABLE_BITS-1:0] : pos_ff[SMALL_TABLE_BITS-1:0]),
      .wr_data (clearing ? '0 : key_ff),
      .rd_addr (rd_addr[SMALL_TABLE_BITS-1:0]),
      .rd_data (small_rd)
   );

   phtt_key_ram #(.ADDR_BITS(LARGE_TABLE_BITS), .DATA_W(KEY_W)) u_large_ram (
      .clock   (clock),
      .wr_en   (clearing || (insert && sel_ff)),
      .wr_addr (clearing ? clr_ff[LARGE_TABLE_BITS-1:0] : pos_ff[LARGE_TABLE_BITS-1:0]),
      .wr_data (clearing ? '0 : key_ff),
      .rd_addr (rd_addr[LARGE_TABLE_BITS-1:0]),
      .rd_data (large_rd)
   );

   assign mask          = sel_ff ? LMASK : SMASK;
   assign home_calc     = hash[LB-1:0] & mask;
   assign hash_sh_small = hash >> SMALL_TABLE_BITS;
   assign hash_sh_large = hash >> LARGE_TABLE_BITS;
   assign offset        = (sel_ff ? hash_sh_large[LB-1:0] : hash_sh_small[LB-1:0]) & mask;
   assign pos2          = (home_ff + offset) & mask;
   assign pos_next      = (pos_ff + LB'(1)) & mask;

   assign rd_data    = sel_ff ? large_rd : small_rd;
   assign key_eq     = (rd_data == key_ff);
   assign slot_empty = (rd_data == '0);
   assign insert     = (state_ff == S_PROBE) && !key_eq && slot_empty && op_ff;

   assign used_sel = sel_ff ? large_used_ff : small_used_ff;
   assign used_inc = (used_sel == COUNT_MAX) ? used_sel : used_sel + USED_W'(1);

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign hash_start = (state_ff == S_IDLE) && req_valid;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      sel_in         = sel_ff;
      home_in        = home_ff;
      pos_in         = pos_ff;
      cnt_in         = cnt_ff;
      small_used_in  = small_used_ff;
      large_used_in  = large_used_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      pend_used_in   = pend_used_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_used_in    = rsp_used_ff;
      rd_addr        = pos_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + LB'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               key_in   = req_key;
               sel_in   = req_table_sel;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               rd_addr  = home_calc;
               home_in  = home_calc;
               state_in = S_HOME;
            end
         end
         S_HOME: begin
            if (key_eq) begin
               pend_status_in = ST_FOUND;
               pend_slot_in   = slot_of(home_ff);
               pend_used_in   = used_sel;
               state_in       = S_RESULT;
            end else begin
               rd_addr  = pos2;
               pos_in   = pos2;
               state_in = S_SECOND;
            end
         end
         S_SECOND: begin
            if (key_eq) begin
               pend_status_in = ST_FOUND;
               pend_slot_in   = slot_of(pos_ff);
               pend_used_in   = used_sel;
               state_in       = S_RESULT;
            end else begin
               rd_addr  = pos_next;
               pos_in   = pos_next;
               cnt_in   = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            // match wins over empty, so a zero key finds an empty slot
            priority if (key_eq) begin
               pend_status_in = ST_FOUND;
               pend_slot_in   = slot_of(pos_ff);
               pend_used_in   = used_sel;
               state_in       = S_RESULT;
            end else if (slot_empty) begin
               if (op_ff) begin
                  pend_status_in = ST_INSERTED;
                  pend_slot_in   = slot_of(pos_ff);
                  pend_used_in   = used_inc;
                  if (sel_ff) begin
                     large_used_in = used_inc;
                  end else begin
                     small_used_in = used_inc;
                  end
               end else begin
                  pend_status_in = ST_NOT_FOUND;
                  pend_slot_in   = '0;
                  pend_used_in   = used_sel;
               end
               state_in = S_RESULT;
            end else if (cnt_ff == mask) begin
               // full circle with no match and no empty slot
               pend_status_in = op_ff ? ST_FULL : ST_NOT_FOUND;
               pend_slot_in   = '0;
               pend_used_in   = used_sel;
               state_in       = S_RESULT;
            end else begin
               rd_addr = pos_next;
               pos_in  = pos_next;
               cnt_in  = cnt_ff + LB'(1);
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_slot_in   = pend_slot_ff;
               rsp_used_in   = pend_used_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         small_used_ff <= '0;
         large_used_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         small_used_ff <= small_used_in;
         large_used_ff <= large_used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff          <= op_in;
      key_ff         <= key_in;
      sel_ff         <= sel_in;
      home_ff        <= home_in;
      pos_ff         <= pos_in;
      cnt_ff         <= cnt_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      pend_used_ff   <= pend_used_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_used_count = rsp_used_ff;

endmodule
`default_nettype wire
